[rtl/egd_pkg.sv]
`default_nettype none
// ============================================================================
// egd_pkg
// Shared types, constants and luma helper for the gradient delta block.
// ============================================================================
package egd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

    localparam int PIX_W   = 8;
    localparam int LUMA_W  = 18;
    localparam int GRAD_W  = LUMA_W + 1;
    localparam int TOTAL_W = 39;
    localparam int COUNT_W = 20;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [LUMA_W-1:0] COEF_RED   = LUMA_W'(299);
    localparam logic [LUMA_W-1:0] COEF_GREEN = LUMA_W'(587);
    localparam logic [LUMA_W-1:0] COEF_BLUE  = LUMA_W'(114);

    typedef logic [LUMA_W-1:0] t_luma;

    typedef struct packed {
        logic [PIX_W-1:0] ref_red;
        logic [PIX_W-1:0] ref_green;
        logic [PIX_W-1:0] ref_blue;
        logic [PIX_W-1:0] cand_red;
        logic [PIX_W-1:0] cand_green;
        logic [PIX_W-1:0] cand_blue;
    } t_in_word;

    typedef struct packed {
        logic [TOTAL_W-1:0] delta_total;
        logic [COUNT_W-1:0] interior_count;
    } t_out_word;

    typedef struct packed {
        t_luma ref_luma;
        t_luma cand_luma;
    } t_luma_pair;

    // line buffer access for one pixel
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [COL_W-1:0] addr;
        t_luma_pair       wdata;
    } t_lb_req;

    // exact luma times 1000
    function automatic t_luma f_luma(input logic [PIX_W-1:0] red,
                                     input logic [PIX_W-1:0] green,
                                     input logic [PIX_W-1:0] blue);
        return LUMA_W'(red) * COEF_RED + LUMA_W'(green) * COEF_GREEN
             + LUMA_W'(blue) * COEF_BLUE;
    endfunction

endpackage
`default_nettype wire

[rtl/egd_line_buf.sv]
`default_nettype none
// ============================================================================
// egd_line_buf
// Two row banks of luma pairs, picked by row parity. Both banks are read at
// the pixel column; the current row's bank is written there, old data read.
// ============================================================================
module egd_line_buf (
    input  wire                  i_clk,
    input  egd_pkg::t_lb_req     i_req,
    output egd_pkg::t_luma_pair  o_rd0,
    output egd_pkg::t_luma_pair  o_rd1
);
    import egd_pkg::*;

    t_luma_pair r_mem0 [MAX_WIDTH];
    t_luma_pair r_mem1 [MAX_WIDTH];
    t_luma_pair r_rd0;
    t_luma_pair r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (!i_req.bank) begin
                r_mem0[i_req.addr] <= i_req.wdata;
            end
            if (i_req.bank) begin
                r_mem1[i_req.addr] <= i_req.wdata;
            end
            r_rd0 <= r_mem0[i_req.addr];
            r_rd1 <= r_mem1[i_req.addr];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule
`default_nettype wire

[rtl/edge_gradient_delta.sv]
`default_nettype none
// ============================================================================
// edge_gradient_delta
// Gradient difference of two RGB images streamed in raster order.
// ============================================================================
// result: the last pixel word of a frame passes the stage 1 and stage 2
//   registers before its result word is registered at the output
// throughput: one pixel word per cycle; a frame's last word waits while an
//   earlier last word is still in the pipeline or its result is held
// reset: width and height 1024, position and sums cleared, line buffers
//   hold no reset value
// ============================================================================
module edge_gradient_delta (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  egd_pkg::t_in_word                    i_in_word,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output egd_pkg::t_out_word                   o_out_word,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [egd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [egd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import egd_pkg::*;

    function automatic t_luma f_adiff(input t_luma a, input t_luma b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [GRAD_W-1:0] f_gdiff(input logic [GRAD_W-1:0] a,
                                                  input logic [GRAD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // configuration and raster position
    logic [WD_W-1:0]    r_width;
    logic [HT_W-1:0]    r_height;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    logic               in_acc;
    logic               cfg_wr;
    logic               col_end;
    logic               row_end;
    logic               next_last;
    logic               next_eval;

    // stage 1: registered luma and line buffer read
    logic               r_s1_vld;
    logic               r_s1_eval;
    logic               r_s1_last;
    logic               r_s1_bank;
    t_luma_pair         r_s1_lum;

    // column history for the gradient window
    t_luma_pair         r_a1;
    t_luma_pair         r_a2;
    t_luma_pair         r_b1;
    t_luma_pair         r_l1;

    // stage 2: gradient pair
    logic               r_s2_vld;
    logic               r_s2_eval;
    logic               r_s2_last;
    logic [GRAD_W-1:0]  r_s2_grad_ref;
    logic [GRAD_W-1:0]  r_s2_grad_cand;

    logic [TOTAL_W-1:0] r_total;
    logic [COUNT_W-1:0] r_count;
    logic [TOTAL_W-1:0] n_total;
    logic [COUNT_W-1:0] n_count;

    logic               r_out_vld;
    t_out_word          r_out_word;

    t_lb_req            lb_req;
    t_luma_pair         lb_rd0;
    t_luma_pair         lb_rd1;
    t_luma_pair         prev_row;
    t_luma_pair         prev2_row;
    logic [GRAD_W-1:0]  n_grad_ref;
    logic [GRAD_W-1:0]  n_grad_cand;
    logic [WD_W-1:0]    n_width;
    logic [HT_W-1:0]    n_height;

    assign col_end   = (WD_W'(r_col) + WD_W'(1)) >= r_width;
    assign row_end   = (HT_W'(r_row) + HT_W'(1)) >= r_height;
    assign next_last = col_end && row_end;
    assign next_eval = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));

    // a last word may only enter when nothing can block its result
    assign o_in_ready  = !(next_last && ((r_s1_vld && r_s1_last) ||
                                         (r_s2_vld && r_s2_last) ||
                                         (r_out_vld && !i_out_ready)));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && ((i_cfg_index == REG_FRAME_WIDTH) ||
                                         (i_cfg_index == REG_FRAME_HEIGHT));

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_index == REG_FRAME_WIDTH) begin
            if (i_cfg_data == '0) begin
                n_width = WD_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                n_width = WD_W'(MAX_WIDTH);
            end else begin
                n_width = WD_W'(i_cfg_data);
            end
        end
        if (i_cfg_index == REG_FRAME_HEIGHT) begin
            if (i_cfg_data == '0) begin
                n_height = HT_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                n_height = HT_W'(MAX_HEIGHT);
            end else begin
                n_height = HT_W'(i_cfg_data);
            end
        end
    end

    always_comb begin
        lb_req.en              = in_acc;
        lb_req.bank            = r_row[0];
        lb_req.addr            = r_col;
        lb_req.wdata.ref_luma  = f_luma(i_in_word.ref_red, i_in_word.ref_green,
                                        i_in_word.ref_blue);
        lb_req.wdata.cand_luma = f_luma(i_in_word.cand_red, i_in_word.cand_green,
                                        i_in_word.cand_blue);
    end

    egd_line_buf u_line_buf (
        .i_clk (i_clk),
        .i_req (lb_req),
        .o_rd0 (lb_rd0),
        .o_rd1 (lb_rd1)
    );

    // the current row's bank holds the row two above
    assign prev_row  = r_s1_bank ? lb_rd0 : lb_rd1;
    assign prev2_row = r_s1_bank ? lb_rd1 : lb_rd0;

    // center is one column back on the row above
    assign n_grad_ref  = GRAD_W'(f_adiff(prev_row.ref_luma, r_a2.ref_luma))
                       + GRAD_W'(f_adiff(r_l1.ref_luma, r_b1.ref_luma));
    assign n_grad_cand = GRAD_W'(f_adiff(prev_row.cand_luma, r_a2.cand_luma))
                       + GRAD_W'(f_adiff(r_l1.cand_luma, r_b1.cand_luma));

    always_comb begin
        n_total = r_total;
        n_count = r_count;
        if (r_s2_vld && r_s2_eval) begin
            n_total = r_total + TOTAL_W'(f_gdiff(r_s2_grad_ref, r_s2_grad_cand));
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WD_W'(MAX_WIDTH);
            r_height  <= HT_W'(MAX_HEIGHT);
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
            r_count   <= '0;
        end else begin
            r_s1_vld <= in_acc;
            r_s2_vld <= r_s1_vld;
            if (cfg_wr) begin
                r_width  <= n_width;
                r_height <= n_height;
                r_col    <= '0;
                r_row    <= '0;
                r_total  <= '0;
                r_count  <= '0;
            end else begin
                if (in_acc) begin
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= row_end ? '0 : r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                if (r_s2_vld && r_s2_last) begin
                    r_total <= '0;
                    r_count <= '0;
                end else begin
                    r_total <= n_total;
                    r_count <= n_count;
                end
            end
            if (r_s2_vld && r_s2_last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_eval          <= next_eval;
            r_s1_last          <= next_last;
            r_s1_bank          <= r_row[0];
            r_s1_lum           <= lb_req.wdata;
        end
        if (r_s1_vld) begin
            r_a2           <= r_a1;
            r_a1           <= prev_row;
            r_b1           <= prev2_row;
            r_l1           <= r_s1_lum;
            r_s2_eval      <= r_s1_eval;
            r_s2_last      <= r_s1_last;
            r_s2_grad_ref  <= n_grad_ref;
            r_s2_grad_cand <= n_grad_cand;
        end
        if (r_s2_vld && r_s2_last) begin
            r_out_word.delta_total    <= n_total;
            r_out_word.interior_count <= n_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // a finished frame never lands on a result still waiting
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_last) |-> !(r_out_vld && !i_out_ready))
        else $error("frame result overran waiting result");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WD_W'(r_col) < r_width) && (HT_W'(r_row) < r_height))
        else $error("raster position beyond frame");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_col == '0) && (r_row == '0) && (r_count == '0))
        else $error("register write did not restart frame");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && next_last && !cfg_wr) |=> (r_col == '0) && (r_row == '0))
        else $error("last word did not wrap raster position");

endmodule
`default_nettype wire

[dv/edge_gradient_delta_tb.sv]
`default_nettype none
// ============================================================================
// edge_gradient_delta_tb
// Self-checking bench: streams pixel-pair words through the gradient delta
// block, scores each word in a local line-buffer model and compares every
// result word against the frame totals that the model expects.
// ============================================================================
module edge_gradient_delta_tb;
    import egd_pkg::*;

    localparam int RED_WEIGHT    = 299;
    localparam int GREEN_WEIGHT  = 587;
    localparam int BLUE_WEIGHT   = 114;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TOP_INDEX     = (1 << CFG_IDX_W) - 1;
    localparam int ITEM_TARGET   = 1000;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_BURSTY} t_pace;
    typedef enum int {STYLE_UNIFORM, STYLE_SMOOTH, STYLE_SATURATED} t_pixel_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  o_cfg_ready;

    // model of the block
    logic [CFG_DATA_W-1:0] frame_w_reg = CFG_DATA_W'(MAX_WIDTH);
    logic [CFG_DATA_W-1:0] frame_h_reg = CFG_DATA_W'(MAX_HEIGHT);
    t_luma                 ref_rows  [2*MAX_WIDTH];
    t_luma                 cand_rows [2*MAX_WIDTH];
    int unsigned           pos_col = 0;
    int unsigned           pos_row = 0;
    logic [39:0]           edge_total = '0;
    logic [20:0]           edge_count = '0;
    t_out_word             due_results[$];

    t_in_word              pixel_queue[$];
    t_out_word             due_word;
    int                    pixels_queued = 0;
    int                    pixels_taken  = 0;
    int                    fail_count    = 0;
    int                    quiet_cycles  = 0;
    bit                    in_fire       = 1'b0;
    bit                    out_fire      = 1'b0;
    bit                    cfg_fire      = 1'b0;
    int                    send_gap      = 0;
    int                    recv_stall    = 0;
    int                    hold_left     = 0;
    int                    hold_asked    = 0;
    int                    hold_taken    = 0;
    t_pace                 send_pace     = PACE_FULL;
    t_pace                 recv_pace     = PACE_FULL;

    edge_gradient_delta dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned pixel_luma(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return RED_WEIGHT * r + GREEN_WEIGHT * g + BLUE_WEIGHT * b;
    endfunction

    function automatic int unsigned abs_delta(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned line_slot(input int unsigned row, input int unsigned col);
        return (row & 1) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // |dx| + |dy| of the pixel one row up; row-2 still sits in this row's slot
    function automatic int unsigned edge_strength(input bit cand_side, input int unsigned row,
                                                  input int unsigned col,
                                                  input int unsigned below);
        int unsigned left, right, above;
        left  = 32'(cand_side ? cand_rows[line_slot(row - 1, col - 1)]
                              : ref_rows[line_slot(row - 1, col - 1)]);
        right = 32'(cand_side ? cand_rows[line_slot(row - 1, col + 1)]
                              : ref_rows[line_slot(row - 1, col + 1)]);
        above = 32'(cand_side ? cand_rows[line_slot(row, col)]
                              : ref_rows[line_slot(row, col)]);
        return abs_delta(right, left) + abs_delta(below, above);
    endfunction

    function automatic void clear_frame();
        pos_col    = 0;
        pos_row    = 0;
        edge_total = '0;
        edge_count = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_FRAME_WIDTH) begin
            frame_w_reg = data;
            clear_frame();
        end else if (idx == REG_FRAME_HEIGHT) begin
            frame_h_reg = data;
            clear_frame();
        end
    endfunction

    function automatic void score_pixel(input t_in_word px);
        int unsigned w, h, col, row, lr, lc, gr, gc;
        t_out_word   res;
        w   = clamp_dim(32'(frame_w_reg), MAX_WIDTH);
        h   = clamp_dim(32'(frame_h_reg), MAX_HEIGHT);
        col = pos_col;
        row = pos_row;
        lr  = pixel_luma(px.ref_red, px.ref_green, px.ref_blue);
        lc  = pixel_luma(px.cand_red, px.cand_green, px.cand_blue);
        if (row >= 2 && col >= 1 && col + 2 <= w) begin
            gr = edge_strength(1'b0, row, col, lr);
            gc = edge_strength(1'b1, row, col, lc);
            edge_total = edge_total + 40'(abs_delta(gr, gc));
            edge_count = edge_count + 21'd1;
        end
        ref_rows[line_slot(row, col)]  = t_luma'(lr);
        cand_rows[line_slot(row, col)] = t_luma'(lc);
        if (col + 1 >= w) begin
            pos_col = 0;
            if (row + 1 >= h) begin
                res = '0;
                if (w >= 3 && h >= 3) begin
                    res.delta_total    = edge_total[TOTAL_W-1:0];
                    res.interior_count = edge_count[COUNT_W-1:0];
                end
                due_results = {due_results, res};
                clear_frame();
            end else begin
                pos_row = row + 1;
            end
        end else begin
            pos_col = col + 1;
        end
    endfunction

    function automatic int pick_gap(input t_pace pace);
        case (pace)
            PACE_FULL: return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
            default: begin
                if ($urandom_range(0, 4) != 0) return 0;
                if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
                return $urandom_range(15, 40);
            end
        endcase
    endfunction

    function automatic t_in_word make_pixel(input t_pixel_style style);
        t_in_word    px;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        px   = bits[$bits(t_in_word)-1:0];
        case (style)
            STYLE_SMOOTH: begin
                // candidate close to reference, small gradient deltas
                px.cand_red   = px.ref_red ^ 8'($urandom_range(0, 3));
                px.cand_green = px.ref_green ^ 8'($urandom_range(0, 3));
                px.cand_blue  = px.ref_blue ^ 8'($urandom_range(0, 3));
            end
            STYLE_SATURATED: begin
                px.ref_red    = {8{bits[48]}};
                px.ref_green  = {8{bits[49]}};
                px.ref_blue   = {8{bits[50]}};
                px.cand_red   = {8{bits[51]}};
                px.cand_green = {8{bits[52]}};
                px.cand_blue  = {8{bits[53]}};
            end
            default: ;
        endcase
        return px;
    endfunction

    function automatic int unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r <= 15) return $urandom_range(1, 6);
        return $urandom_range(7, 16);
    endfunction

    function automatic void offer_pixel(input t_in_word px);
        pixel_queue = {pixel_queue, px};
        pixels_queued++;
    endfunction

    task automatic queue_random(input int unsigned n, input t_pixel_style style);
        @(posedge clk);
        repeat (n) offer_pixel(make_pixel(style));
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pixels_taken != pixels_queued || due_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // pixel word driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                in_word  <= pixel_queue.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap(send_pace);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off when the test asks for one
    always @(negedge clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            out_ready <= 1'b0;
        end else begin
            recv_stall = pick_gap(recv_pace);
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: model update, result check, watchdog
    always @(posedge clk) begin
        in_fire  = rst_n && in_valid && o_in_ready;
        out_fire = rst_n && o_out_valid && out_ready;
        cfg_fire = rst_n && cfg_valid && o_cfg_ready;
        if (cfg_fire) apply_register(cfg_index, cfg_data);
        if (in_fire) begin
            score_pixel(in_word);
            pixels_taken++;
        end
        if (out_fire) begin
            if (due_results.size() == 0) begin
                $error("result word with none expected: delta_total %0d interior_count %0d",
                       o_out_word.delta_total, o_out_word.interior_count);
                fail_count++;
            end else begin
                due_word = due_results.pop_front();
                if (o_out_word.delta_total !== due_word.delta_total) begin
                    $error("delta_total expected %0d actual %0d",
                           due_word.delta_total, o_out_word.delta_total);
                    fail_count++;
                end
                if (o_out_word.interior_count !== due_word.interior_count) begin
                    $error("interior_count expected %0d actual %0d",
                           due_word.interior_count, o_out_word.interior_count);
                    fail_count++;
                end
            end
        end
        if (!rst_n || in_fire || out_fire || cfg_fire) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL edge_gradient_delta");
            $finish;
        end
    end

    initial begin
        t_in_word              px;
        int unsigned           n;
        int unsigned           cur_w;
        int unsigned           cur_h;
        logic [1:0]            write_mask;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 frame: bright right column and bottom row in the reference only
        send_pace = t_pace'($urandom_range(0, 2));
        recv_pace = t_pace'($urandom_range(0, 2));
        set_register(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        @(posedge clk);
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                px = '0;
                if (x == 2 || y == 2) begin
                    px.ref_red   = '1;
                    px.ref_green = '1;
                    px.ref_blue  = '1;
                end
                offer_pixel(px);
            end
        end
        wait_idle();

        // unknown index mid-frame must not restart the frame
        queue_random(4, STYLE_UNIFORM);
        wait_idle();
        set_register(CFG_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, TOP_INDEX)), '0);
        queue_random(5, STYLE_SATURATED);
        wait_idle();

        // restart mid-frame, then zero dims acting as a 1x1 frame
        queue_random(2, STYLE_UNIFORM);
        wait_idle();
        set_register(REG_FRAME_WIDTH, '0);
        set_register(REG_FRAME_HEIGHT, '0);
        @(posedge clk);
        offer_pixel('1);
        wait_idle();

        // frame too small for any interior pixel
        set_register(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        @(posedge clk);
        repeat (4) offer_pixel('0);
        wait_idle();

        // back-pressure: one result per word while the receiver holds off
        send_pace = PACE_FULL;
        recv_pace = PACE_LIGHT;
        set_register(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        @(posedge clk);
        hold_asked++;
        queue_random(60, STYLE_UNIFORM);
        wait_idle();

        // oversized registers clamp to the maximum, so a partial row or
        // column of such a frame must not end it
        send_pace = PACE_LIGHT;
        recv_pace = PACE_BURSTY;
        set_register(REG_FRAME_WIDTH, '1);
        set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        queue_random(150, STYLE_SMOOTH);
        wait_idle();
        set_register(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        set_register(REG_FRAME_HEIGHT, '1);
        queue_random(150, STYLE_SATURATED);
        wait_idle();
        set_register(REG_FRAME_WIDTH, CFG_DATA_W'(4));
        set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
        cur_w = 4;
        cur_h = 4;

        // random frames
        while (pixels_queued < ITEM_TARGET) begin
            send_pace = t_pace'($urandom_range(0, 2));
            recv_pace = t_pace'($urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0) begin
                set_register(CFG_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, TOP_INDEX)),
                             CFG_DATA_W'($urandom));
            end
            write_mask = 2'($urandom_range(1, 3));
            if (write_mask[0]) begin
                cur_w = pick_dim();
                set_register(REG_FRAME_WIDTH, CFG_DATA_W'(cur_w));
            end
            if (write_mask[1]) begin
                cur_h = pick_dim();
                set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(cur_h));
            end
            n = clamp_dim(cur_w, MAX_WIDTH) * clamp_dim(cur_h, MAX_HEIGHT)
                * $urandom_range(1, 3);
            // some phases stop mid-frame; the next register write restarts it
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
            queue_random(n, t_pixel_style'($urandom_range(0, 2)));
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("PASS edge_gradient_delta");
        end else begin
            $display("FAIL edge_gradient_delta");
        end
        $finish;
    end

endmodule
`default_nettype wire
